FILE: hdl/lzwd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwd_pkg
// types and constants for the fixed 12-bit lzw decoder
// ----------------------------------------------------------------------------
package lzwd_pkg;

   localparam int CODE_BITS = 12;
   localparam int CHAR_BITS = 8;
   localparam int DICT_DEPTH = 1 << CODE_BITS;

   typedef logic [CODE_BITS-1:0] code_type;
   typedef logic [CODE_BITS:0]   entry_count_type;
   typedef logic [CHAR_BITS-1:0] char_type;

   localparam entry_count_type FIRST_FREE = entry_count_type'(256);
   localparam entry_count_type DICT_FULL  = entry_count_type'(DICT_DEPTH);
   localparam code_type STACK_LIMIT       = code_type'(DICT_DEPTH - 1);
   localparam code_type STACK_NEAR_LIMIT  = code_type'(DICT_DEPTH - 2);

   typedef struct packed {
      code_type prefix;
      char_type suffix;
   } dict_entry_type;

   function automatic logic is_literal(input code_type code);
      is_literal = (code[CODE_BITS-1:CHAR_BITS] == '0);
   endfunction

endpackage

FILE: hdl/lzw_decoder_12bit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_decoder_12bit_top
// lzw decompressor, fixed 12-bit codes packed msb first, pull-paced output
// a pull passes through S_POP and S_DONE; a byte that forms no code goes to S_DONE
// a literal code passes S_HEAD, S_START and S_DONE; a longer code also walks its chain in S_WALK
// the chain walk does one dictionary read per cycle, a pull one stack read
// one word in flight; the next word is taken while a result waits
// synchronous reset clears control state; dictionary and stack are not cleared
// ----------------------------------------------------------------------------
module lzw_decoder_12bit_top (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_func,
   input  logic [7:0] req_in_byte,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_out_valid,
   output logic [7:0] rsp_out_byte,
   output logic rsp_string_end,
   output logic rsp_refused,
   output logic rsp_bad_code
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP,
      S_HEAD,
      S_START,
      S_WALK,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   lzwd_pkg::code_type        cnt_ff, cnt_in;
   lzwd_pkg::entry_count_type ne_ff, ne_in;
   lzwd_pkg::code_type        prev_code_ff, prev_code_in;
   lzwd_pkg::char_type        prev_head_ff, prev_head_in;
   logic                      started_ff, started_in;
   logic [1:0]                phase_ff, phase_in;
   logic [7:0]                held_ff, held_in;
   logic                      err_ff, err_in;
   lzwd_pkg::code_type        code_ff, code_in;
   lzwd_pkg::code_type        cur_ff, cur_in;

   logic                      res_valid_ff, res_valid_in;
   lzwd_pkg::char_type        res_byte_ff, res_byte_in;
   logic                      res_end_ff, res_end_in;
   logic                      res_refused_ff, res_refused_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_out_valid_ff, rsp_out_valid_in;
   lzwd_pkg::char_type        rsp_out_byte_ff, rsp_out_byte_in;
   logic                      rsp_string_end_ff, rsp_string_end_in;
   logic                      rsp_refused_ff, rsp_refused_in;
   logic                      rsp_bad_code_ff, rsp_bad_code_in;

   // memories
   lzwd_pkg::dict_entry_type  dict_mem [lzwd_pkg::DICT_DEPTH];
   lzwd_pkg::char_type        head_mem [lzwd_pkg::DICT_DEPTH];
   lzwd_pkg::char_type        stk_mem  [lzwd_pkg::DICT_DEPTH];

   lzwd_pkg::dict_entry_type  dict_rdata_ff, dict_wdata;
   lzwd_pkg::char_type        head_rdata_ff, stk_rdata_ff, stk_wdata;
   lzwd_pkg::code_type        dict_raddr, head_raddr, stk_raddr;
   logic                      dict_we, stk_we;

   lzwd_pkg::code_type        unpacked;
   lzwd_pkg::char_type        last_char;
   logic                      accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   assign unpacked = (phase_ff == 2'd1) ? {held_ff, req_in_byte[7:4]}
                                        : {held_ff[3:0], req_in_byte};

   assign head_raddr = unpacked;
   assign stk_raddr  = cnt_ff - lzwd_pkg::code_type'(1);
   assign dict_raddr = (state_ff == S_WALK) ? dict_rdata_ff.prefix : cur_ff;

   assign last_char = lzwd_pkg::is_literal(code_ff) ? code_ff[7:0] :
                      ({1'b0, code_ff} == ne_ff) ? prev_head_ff : head_rdata_ff;

   assign dict_wdata.prefix = prev_code_ff;
   assign dict_wdata.suffix = last_char;

   always_ff @(posedge clock) begin
      if (dict_we) begin
         dict_mem[ne_ff[lzwd_pkg::CODE_BITS-1:0]] <= dict_wdata;
         head_mem[ne_ff[lzwd_pkg::CODE_BITS-1:0]] <= prev_head_ff;
      end
      dict_rdata_ff <= dict_mem[dict_raddr];
      head_rdata_ff <= head_mem[head_raddr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[cnt_ff] <= stk_wdata;
      end
      stk_rdata_ff <= stk_mem[stk_raddr];
   end

   always_comb begin
      state_in          = state_ff;
      cnt_in            = cnt_ff;
      ne_in             = ne_ff;
      prev_code_in      = prev_code_ff;
      prev_head_in      = prev_head_ff;
      started_in        = started_ff;
      phase_in          = phase_ff;
      held_in           = held_ff;
      err_in            = err_ff;
      code_in           = code_ff;
      cur_in            = cur_ff;
      res_valid_in      = res_valid_ff;
      res_byte_in       = res_byte_ff;
      res_end_in        = res_end_ff;
      res_refused_in    = res_refused_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_out_valid_in  = rsp_out_valid_ff;
      rsp_out_byte_in   = rsp_out_byte_ff;
      rsp_string_end_in = rsp_string_end_ff;
      rsp_refused_in    = rsp_refused_ff;
      rsp_bad_code_in   = rsp_bad_code_ff;
      dict_we           = 1'b0;
      stk_we            = 1'b0;
      stk_wdata         = dict_rdata_ff.suffix;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_valid_in   = 1'b0;
               res_byte_in    = '0;
               res_end_in     = 1'b0;
               res_refused_in = 1'b0;
               state_in       = S_DONE;
               if (req_func) begin
                  if (cnt_ff != '0) begin
                     cnt_in   = cnt_ff - lzwd_pkg::code_type'(1);
                     state_in = S_POP;
                  end
               end else if (cnt_ff != '0) begin
                  res_refused_in = 1'b1;
               end else if (!err_ff) begin
                  if (phase_ff == 2'd0) begin
                     held_in  = req_in_byte;
                     phase_in = 2'd1;
                  end else begin
                     code_in = unpacked;
                     if (phase_ff == 2'd1) begin
                        held_in  = {4'b0, req_in_byte[3:0]};
                        phase_in = 2'd2;
                     end else begin
                        held_in  = '0;
                        phase_in = 2'd0;
                     end
                     if (!started_ff) begin
                        if (!lzwd_pkg::is_literal(unpacked)) begin
                           err_in = 1'b1;
                        end else begin
                           stk_we       = 1'b1;
                           stk_wdata    = unpacked[7:0];
                           cnt_in       = cnt_ff + lzwd_pkg::code_type'(1);
                           prev_code_in = unpacked;
                           prev_head_in = unpacked[7:0];
                           started_in   = 1'b1;
                        end
                     end else if ({1'b0, unpacked} > ne_ff) begin
                        err_in = 1'b1;
                     end else begin
                        state_in = S_HEAD;
                     end
                  end
               end
            end
         end
         S_POP: begin
            res_valid_in = 1'b1;
            res_byte_in  = stk_rdata_ff;
            res_end_in   = (cnt_ff == '0);
            state_in     = S_DONE;
         end
         S_HEAD: begin
            if (ne_ff == lzwd_pkg::DICT_FULL) begin
               ne_in = lzwd_pkg::FIRST_FREE;
            end else begin
               dict_we = 1'b1;
               ne_in   = ne_ff + lzwd_pkg::entry_count_type'(1);
            end
            prev_head_in = last_char;
            prev_code_in = code_ff;
            cur_in       = code_ff;
            state_in     = S_START;
         end
         S_START: begin
            if (cnt_ff == lzwd_pkg::STACK_LIMIT) begin
               err_in   = 1'b1;
               state_in = S_DONE;
            end else if (lzwd_pkg::is_literal(cur_ff)) begin
               stk_we    = 1'b1;
               stk_wdata = cur_ff[7:0];
               cnt_in    = cnt_ff + lzwd_pkg::code_type'(1);
               state_in  = S_DONE;
            end else begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            stk_we = 1'b1;
            cnt_in = cnt_ff + lzwd_pkg::code_type'(1);
            if (lzwd_pkg::is_literal(dict_rdata_ff.prefix)) begin
               cur_in   = dict_rdata_ff.prefix;
               state_in = S_START;
            end else if (cnt_ff >= lzwd_pkg::STACK_NEAR_LIMIT) begin
               err_in   = 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_out_valid_in  = res_valid_ff;
               rsp_out_byte_in   = res_byte_ff;
               rsp_string_end_in = res_end_ff;
               rsp_refused_in    = res_refused_ff;
               rsp_bad_code_in   = err_ff;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         ne_ff        <= lzwd_pkg::FIRST_FREE;
         prev_code_ff <= '0;
         started_ff   <= 1'b0;
         phase_ff     <= 2'd0;
         held_ff      <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ne_ff        <= ne_in;
         prev_code_ff <= prev_code_in;
         started_ff   <= started_in;
         phase_ff     <= phase_in;
         held_ff      <= held_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prev_head_ff      <= prev_head_in;
      code_ff           <= code_in;
      cur_ff            <= cur_in;
      res_valid_ff      <= res_valid_in;
      res_byte_ff       <= res_byte_in;
      res_end_ff        <= res_end_in;
      res_refused_ff    <= res_refused_in;
      rsp_out_valid_ff  <= rsp_out_valid_in;
      rsp_out_byte_ff   <= rsp_out_byte_in;
      rsp_string_end_ff <= rsp_string_end_in;
      rsp_refused_ff    <= rsp_refused_in;
      rsp_bad_code_ff   <= rsp_bad_code_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_valid  = rsp_out_valid_ff;
   assign rsp_out_byte   = rsp_out_byte_ff;
   assign rsp_string_end = rsp_string_end_ff;
   assign rsp_refused    = rsp_refused_ff;
   assign rsp_bad_code   = rsp_bad_code_ff;

`ifndef NO_ASSERTIONS
   // error flag is sticky
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      err_ff |=> err_ff)
      else $error("error flag cleared without reset");

   // next entry stays in the dictionary range
   a_ne_range: assert property (@(posedge clock) disable iff (reset)
      (ne_ff >= lzwd_pkg::FIRST_FREE) && (ne_ff <= lzwd_pkg::DICT_FULL))
      else $error("next entry out of range");

   // a refused word leaves the stack alone
   a_refuse_hold: assert property (@(posedge clock) disable iff (reset)
      accept && !req_func && (cnt_ff != '0) |=> $stable(cnt_ff))
      else $error("stack changed on a refused word");

   // a refused word never carries a decoded byte
   a_refuse_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_refused |-> !rsp_out_valid)
      else $error("refused word carries a byte");
`endif

endmodule
